[src/sjt_pkg.sv]
// Shared types, constants and the microprogram of the segment join test.
package sjt_pkg;

   // Geometry widths.
   localparam int CW        = 12;                 // coordinate width
   localparam int IN_W      = 12;                 // width of the coordinate ports
   localparam int NUM_COORD = 8;
   localparam int THR_W     = 12;                 // threshold register width
   localparam int RATIO_W   = 8;                  // Q0.8 ratio register width
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W = 3;
   localparam int SUM_W     = 2 * CW + 1;         // sum of two squared differences
   localparam int DIST_W    = 25;                 // width of the distance result field
   localparam int MUL_A_W   = SUM_W;
   localparam int MUL_B_W   = (CW > 2 * RATIO_W) ? CW : 2 * RATIO_W;
   localparam int P_W       = MUL_A_W + MUL_B_W;
   localparam int THR2_W    = 2 * THR_W;
   localparam int JW        = ((CW > THR_W) ? CW : THR_W) + RATIO_W;
   localparam int Q_SHIFT   = 2 * RATIO_W;
   localparam int CLW       = (P_W > THR2_W + Q_SHIFT) ? P_W : THR2_W + Q_SHIFT;
   localparam int SAT_W     = 2 * 16 + 2;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Coordinate slots of a segment.
   localparam int IDX_MIN_X   = 0;
   localparam int IDX_MAX_X   = 1;
   localparam int IDX_MIN_Y   = 2;
   localparam int IDX_MAX_Y   = 3;
   localparam int IDX_START_X = 4;
   localparam int IDX_START_Y = 5;
   localparam int IDX_END_X   = 6;
   localparam int IDX_END_Y   = 7;

   // Opcodes of an input item.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPARE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_THR     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_RATIO   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVL_THR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OVL_RATIO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_THR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_RATIO = 3'd5;

   typedef logic [CW-1:0] coord_type;
   typedef logic [NUM_COORD-1:0][CW-1:0] seg_type;

   typedef struct packed {
      logic [THR_W-1:0]   gap_thr;
      logic [RATIO_W-1:0] gap_ratio;
      logic [THR_W-1:0]   ovl_thr;
      logic [RATIO_W-1:0] ovl_ratio;
      logic [THR_W-1:0]   close_thr;
      logic [RATIO_W-1:0] close_ratio;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gap_thr:     THR_W'(18),
      gap_ratio:   RATIO_W'(128),
      ovl_thr:     THR_W'(8),
      ovl_ratio:   RATIO_W'(51),
      close_thr:   THR_W'(14),
      close_ratio: RATIO_W'(128)
   };

   typedef enum logic [2:0] {
      CAUSE_NONE       = 3'd0,
      CAUSE_X_OVERLAP  = 3'd1,
      CAUSE_X_GAP      = 3'd2,
      CAUSE_Y_OVERLAP  = 3'd3,
      CAUSE_Y_GAP      = 3'd4,
      CAUSE_ENDS_APART = 3'd5
   } cause_type;

   // Control word fields.
   typedef enum logic [1:0] {AX_NONE, AX_X, AX_Y} axis_type;
   typedef enum logic [1:0] {JG_NONE, JG_X, JG_Y, JG_CLOSE} judge_type;
   typedef enum logic [2:0] {
      MS_NONE, MS_RATIO_SPAN, MS_DIFF_SQ, MS_THR_SQ, MS_CRATIO_SQ, MS_LIMIT
   } mul_type;
   typedef enum logic [3:0] {
      PR_SS_X, PR_SS_Y, PR_SE_X, PR_SE_Y, PR_ES_X, PR_ES_Y, PR_EE_X, PR_EE_Y,
      PR_RL_X, PR_RL_Y, PR_CL_X, PR_CL_Y
   } pair_type;
   typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD} acc_type;
   typedef enum logic [2:0] {
      DST_NONE, DST_DMIN_INIT, DST_DMIN_MIN, DST_LEN_INIT, DST_LEN_MIN
   } dst_type;
   typedef enum logic [1:0] {SQ_NEXT, SQ_JUMP_REJECT, SQ_EMIT} seq_type;

   localparam int UPC_W = 5;
   localparam logic [UPC_W-1:0] UPC_EMIT = UPC_W'(20);

   typedef struct packed {
      axis_type         axis;
      judge_type        judge;
      mul_type          mul;
      pair_type         pair;
      acc_type          acc;
      dst_type          dst;
      logic             save_thr2;
      seq_type          seq;
      logic [UPC_W-1:0] target;
   } ucode_type;

   localparam ucode_type UC_NOP = '{
      axis: AX_NONE, judge: JG_NONE, mul: MS_NONE, pair: PR_SS_X, acc: ACC_NONE,
      dst: DST_NONE, save_thr2: 1'b0, seq: SQ_NEXT, target: '0
   };

   function automatic coord_type absdiff(input coord_type a, input coord_type b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Microprogram. A product is registered in the step that issues it, and the
   // next step sums it into the accumulator.
   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type uc;
      uc = UC_NOP;
      case (addr)
         UPC_W'(0): begin
            uc.axis = AX_X;
         end
         UPC_W'(1): begin
            uc.mul = MS_RATIO_SPAN;
         end
         UPC_W'(2): begin
            uc.judge  = JG_X;
            uc.axis   = AX_Y;
            uc.seq    = SQ_JUMP_REJECT;
            uc.target = UPC_EMIT;
         end
         UPC_W'(3): begin
            uc.mul = MS_RATIO_SPAN;
         end
         UPC_W'(4): begin
            uc.judge  = JG_Y;
            uc.seq    = SQ_JUMP_REJECT;
            uc.target = UPC_EMIT;
            uc.mul    = MS_DIFF_SQ;
            uc.pair   = PR_SS_X;
         end
         UPC_W'(5): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_SS_Y;
            uc.acc = ACC_LOAD;
         end
         UPC_W'(6): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_SE_X;
            uc.acc = ACC_ADD;
         end
         UPC_W'(7): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_SE_Y;
            uc.acc = ACC_LOAD;
            uc.dst = DST_DMIN_INIT;
         end
         UPC_W'(8): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_ES_X;
            uc.acc = ACC_ADD;
         end
         UPC_W'(9): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_ES_Y;
            uc.acc = ACC_LOAD;
            uc.dst = DST_DMIN_MIN;
         end
         UPC_W'(10): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_EE_X;
            uc.acc = ACC_ADD;
         end
         UPC_W'(11): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_EE_Y;
            uc.acc = ACC_LOAD;
            uc.dst = DST_DMIN_MIN;
         end
         UPC_W'(12): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_RL_X;
            uc.acc = ACC_ADD;
         end
         UPC_W'(13): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_RL_Y;
            uc.acc = ACC_LOAD;
            uc.dst = DST_DMIN_MIN;
         end
         UPC_W'(14): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_CL_X;
            uc.acc = ACC_ADD;
         end
         UPC_W'(15): begin
            uc.mul = MS_DIFF_SQ;
            uc.pair = PR_CL_Y;
            uc.acc = ACC_LOAD;
            uc.dst = DST_LEN_INIT;
         end
         UPC_W'(16): begin
            uc.mul = MS_THR_SQ;
            uc.acc = ACC_ADD;
         end
         UPC_W'(17): begin
            uc.mul = MS_CRATIO_SQ;
            uc.save_thr2 = 1'b1;
            uc.dst = DST_LEN_MIN;
         end
         UPC_W'(18): begin
            uc.mul = MS_LIMIT;
         end
         UPC_W'(19): begin
            uc.judge = JG_CLOSE;
         end
         UPC_EMIT: begin
            uc.seq = SQ_EMIT;
         end
         default: begin
            uc.seq = SQ_EMIT;
         end
      endcase
      return uc;
   endfunction

endpackage

[src/sjt_seq.sv]
// Microsequencer: step counter, control store lookup and conditional jumps.
module sjt_seq import sjt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      reject,
   input  logic      out_free,
   output logic      busy,
   output logic      emit,
   output ucode_type ctl
);

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] pc_ff, pc_in;
   ucode_type        word;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   always_comb begin
      word    = ucode_rom(pc_ff);
      ctl     = busy_ff ? word : UC_NOP;
      busy_in = busy_ff;
      pc_in   = pc_ff;
      emit    = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end else if (busy_ff) begin
         case (word.seq)
            SQ_NEXT: begin
               pc_in = pc_ff + UPC_W'(1);
            end
            SQ_JUMP_REJECT: begin
               pc_in = reject ? word.target : pc_ff + UPC_W'(1);
            end
            SQ_EMIT: begin
               // Hold here until the output register can take the result.
               if (out_free) begin
                  emit    = 1'b1;
                  busy_in = 1'b0;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;

endmodule

[src/sjt_dp.sv]
// Datapath: segment registers, axis measure, shared multiplier, accumulator and judges.
module sjt_dp import sjt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_en,
   input  logic              start_en,
   input  seg_type           seg_in,
   input  cfg_type           cfg,
   input  ucode_type         ctl,
   output logic              reject,
   output cause_type         cause,
   output logic [DIST_W-1:0] dist_sq
);

   seg_type             ref_ff, ref_in;
   seg_type             cand_ff, cand_in;
   coord_type           span_ff, span_in;
   coord_type           amt_ff, amt_in;
   logic                ovl_ff, ovl_in;
   logic [P_W-1:0]      prod_ff, prod_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]    dmin_ff, dmin_in;
   logic [SUM_W-1:0]    lmin_ff, lmin_in;
   logic [THR2_W-1:0]   thr2_ff, thr2_in;
   cause_type           cause_ff, cause_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;

   coord_type           lo1, hi1, lo2, hi2, lo, hi, s1, s2;
   coord_type           pa, pb, diff;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [THR_W-1:0]    jthr;
   logic [JW-1:0]       jprod, jthr_sh, jbound, jamt;
   logic                axis_reject;
   logic [CLW-1:0]      lim_thr, lim_prod, lim, cdist;
   logic                apart;
   logic [DIST_W-1:0]   dsat;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= '0;
      end else begin
         ref_ff <= ref_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      span_ff  <= span_in;
      amt_ff   <= amt_in;
      ovl_ff   <= ovl_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      dmin_ff  <= dmin_in;
      lmin_ff  <= lmin_in;
      thr2_ff  <= thr2_in;
      cause_ff <= cause_in;
      dist_ff  <= dist_in;
   end

   // Box measure of one axis.
   always_comb begin
      if (ctl.axis == AX_Y) begin
         lo1 = ref_ff[IDX_MIN_Y];
         hi1 = ref_ff[IDX_MAX_Y];
         lo2 = cand_ff[IDX_MIN_Y];
         hi2 = cand_ff[IDX_MAX_Y];
      end else begin
         lo1 = ref_ff[IDX_MIN_X];
         hi1 = ref_ff[IDX_MAX_X];
         lo2 = cand_ff[IDX_MIN_X];
         hi2 = cand_ff[IDX_MAX_X];
      end
      s1 = absdiff(lo1, hi1);
      s2 = absdiff(lo2, hi2);
      lo = (lo1 > lo2) ? lo1 : lo2;
      hi = (hi1 < hi2) ? hi1 : hi2;
   end

   // Endpoint pair for the squarer.
   always_comb begin
      case (ctl.pair)
         PR_SS_X: begin pa = ref_ff[IDX_START_X];  pb = cand_ff[IDX_START_X]; end
         PR_SS_Y: begin pa = ref_ff[IDX_START_Y];  pb = cand_ff[IDX_START_Y]; end
         PR_SE_X: begin pa = ref_ff[IDX_START_X];  pb = cand_ff[IDX_END_X];   end
         PR_SE_Y: begin pa = ref_ff[IDX_START_Y];  pb = cand_ff[IDX_END_Y];   end
         PR_ES_X: begin pa = ref_ff[IDX_END_X];    pb = cand_ff[IDX_START_X]; end
         PR_ES_Y: begin pa = ref_ff[IDX_END_Y];    pb = cand_ff[IDX_START_Y]; end
         PR_EE_X: begin pa = ref_ff[IDX_END_X];    pb = cand_ff[IDX_END_X];   end
         PR_EE_Y: begin pa = ref_ff[IDX_END_Y];    pb = cand_ff[IDX_END_Y];   end
         PR_RL_X: begin pa = ref_ff[IDX_START_X];  pb = ref_ff[IDX_END_X];    end
         PR_RL_Y: begin pa = ref_ff[IDX_START_Y];  pb = ref_ff[IDX_END_Y];    end
         PR_CL_X: begin pa = cand_ff[IDX_START_X]; pb = cand_ff[IDX_END_X];   end
         PR_CL_Y: begin pa = cand_ff[IDX_START_Y]; pb = cand_ff[IDX_END_Y];   end
         default: begin pa = '0;                   pb = '0;                   end
      endcase
      diff = absdiff(pa, pb);
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctl.mul)
         MS_RATIO_SPAN: begin
            mul_a = MUL_A_W'(span_ff);
            mul_b = MUL_B_W'(ovl_ff ? cfg.ovl_ratio : cfg.gap_ratio);
         end
         MS_DIFF_SQ: begin
            mul_a = MUL_A_W'(diff);
            mul_b = MUL_B_W'(diff);
         end
         MS_THR_SQ: begin
            mul_a = MUL_A_W'(cfg.close_thr);
            mul_b = MUL_B_W'(cfg.close_thr);
         end
         MS_CRATIO_SQ: begin
            mul_a = MUL_A_W'(cfg.close_ratio);
            mul_b = MUL_B_W'(cfg.close_ratio);
         end
         MS_LIMIT: begin
            // The squared close ratio is still in the product register.
            mul_a = MUL_A_W'(lmin_ff);
            mul_b = prod_ff[MUL_B_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Axis judge: scaled overlap or gap against max(ratio * span, threshold).
   always_comb begin
      jthr        = ovl_ff ? cfg.ovl_thr : cfg.gap_thr;
      jprod       = prod_ff[JW-1:0];
      jthr_sh     = JW'(jthr) << RATIO_W;
      jbound      = (jprod > jthr_sh) ? jprod : jthr_sh;
      jamt        = JW'(amt_ff) << RATIO_W;
      axis_reject = (jamt >= jbound);
      reject      = ((ctl.judge == JG_X) || (ctl.judge == JG_Y)) && axis_reject;
   end

   // Closeness judge.
   always_comb begin
      lim_thr  = CLW'(thr2_ff) << Q_SHIFT;
      lim_prod = CLW'(prod_ff);
      lim      = (lim_thr > lim_prod) ? lim_thr : lim_prod;
      cdist    = CLW'(dmin_ff) << Q_SHIFT;
      apart    = (cdist > lim);
      dsat     = (SAT_W'(dmin_ff) > SAT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(dmin_ff);
   end

   always_comb begin
      ref_in   = load_en ? seg_in : ref_ff;
      cand_in  = start_en ? seg_in : cand_ff;
      span_in  = span_ff;
      amt_in   = amt_ff;
      ovl_in   = ovl_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      dmin_in  = dmin_ff;
      lmin_in  = lmin_ff;
      thr2_in  = thr2_ff;
      cause_in = cause_ff;
      dist_in  = dist_ff;

      if (ctl.axis != AX_NONE) begin
         span_in = (s1 < s2) ? s1 : s2;
         ovl_in  = (lo < hi);
         amt_in  = (lo < hi) ? hi - lo : lo - hi;
      end

      if (ctl.mul != MS_NONE) begin
         prod_in = P_W'(mul_a) * P_W'(mul_b);
      end

      case (ctl.acc)
         ACC_LOAD: acc_in = SUM_W'(prod_ff);
         ACC_ADD:  acc_in = acc_ff + SUM_W'(prod_ff);
         default:  acc_in = acc_ff;
      endcase

      case (ctl.dst)
         DST_DMIN_INIT: dmin_in = acc_ff;
         DST_DMIN_MIN:  dmin_in = (acc_ff < dmin_ff) ? acc_ff : dmin_ff;
         DST_LEN_INIT:  lmin_in = acc_ff;
         DST_LEN_MIN:   lmin_in = (acc_ff < lmin_ff) ? acc_ff : lmin_ff;
         default: begin
         end
      endcase

      if (ctl.save_thr2) begin
         thr2_in = THR2_W'(prod_ff);
      end

      if (start_en) begin
         cause_in = CAUSE_NONE;
         dist_in  = '0;
      end else begin
         case (ctl.judge)
            JG_X: begin
               if (axis_reject) begin
                  cause_in = ovl_ff ? CAUSE_X_OVERLAP : CAUSE_X_GAP;
               end
            end
            JG_Y: begin
               if (axis_reject) begin
                  cause_in = ovl_ff ? CAUSE_Y_OVERLAP : CAUSE_Y_GAP;
               end
            end
            JG_CLOSE: begin
               cause_in = apart ? CAUSE_ENDS_APART : CAUSE_NONE;
               dist_in  = dsat;
            end
            default: begin
            end
         endcase
      end
   end

   assign cause   = cause_ff;
   assign dist_sq = dist_ff;

endmodule

[src/segment_join_test.sv]
// Top level of the segment join test: ports, configuration registers, result register.
//
// Input channel (req_*): one transfer is a segment. Opcode load stores it as the
// reference and gives no result; opcode compare tests it against the reference
// and gives exactly one result on the rsp_* channel.
// A compare runs a microprogram of up to 21 steps: it ends early when the x or y
// box test rejects and runs every step when the endpoint test runs, since the
// single shared multiplier forms its seventeen products one per step. req_stall
// is high while a compare runs. The result sits in an output register and
// appears in the cycle after the last step; a new item is taken while it waits.
// When rsp_stall holds a result, a finished compare waits on its last step until
// the register is free.
// Configuration (csr_*) is always ready and is meant to be written while the
// block is idle; indexes past the last register are ignored.
// Synchronous reset restores the register defaults, clears the reference
// segment to all zero and drops the result valid.
module segment_join_test import sjt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [IN_W-1:0]       req_box_min_x,
   input  logic [IN_W-1:0]       req_box_max_x,
   input  logic [IN_W-1:0]       req_box_min_y,
   input  logic [IN_W-1:0]       req_box_max_y,
   input  logic [IN_W-1:0]       req_start_x,
   input  logic [IN_W-1:0]       req_start_y,
   input  logic [IN_W-1:0]       req_end_x,
   input  logic [IN_W-1:0]       req_end_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_can_join,
   output logic [2:0]            rsp_reject_cause,
   output logic [DIST_W-1:0]     rsp_nearest_end_dist_sq,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type           cfg_ff, cfg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cause_type         rsp_cause_ff, rsp_cause_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;

   logic              busy, emit, reject, out_free;
   logic              req_take, load_en, start_en;
   seg_type           seg_in;
   ucode_type         ctl;
   cause_type         cause;
   logic [DIST_W-1:0] dist_sq;

   assign req_stall = busy;
   assign req_take  = req_valid && !req_stall;
   assign load_en   = req_take && (req_opcode == OP_LOAD);
   assign start_en  = req_take && (req_opcode == OP_COMPARE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      seg_in[IDX_MIN_X]   = CW'(req_box_min_x);
      seg_in[IDX_MAX_X]   = CW'(req_box_max_x);
      seg_in[IDX_MIN_Y]   = CW'(req_box_min_y);
      seg_in[IDX_MAX_Y]   = CW'(req_box_max_y);
      seg_in[IDX_START_X] = CW'(req_start_x);
      seg_in[IDX_START_Y] = CW'(req_start_y);
      seg_in[IDX_END_X]   = CW'(req_end_x);
      seg_in[IDX_END_Y]   = CW'(req_end_y);
   end

   sjt_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start_en),
      .reject   (reject),
      .out_free (out_free),
      .busy     (busy),
      .emit     (emit),
      .ctl      (ctl)
   );

   sjt_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .load_en  (load_en),
      .start_en (start_en),
      .seg_in   (seg_in),
      .cfg      (cfg_ff),
      .ctl      (ctl),
      .reject   (reject),
      .cause    (cause),
      .dist_sq  (dist_sq)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAP_THR:     cfg_in.gap_thr     = csr_data[THR_W-1:0];
            CSR_GAP_RATIO:   cfg_in.gap_ratio   = csr_data[RATIO_W-1:0];
            CSR_OVL_THR:     cfg_in.ovl_thr     = csr_data[THR_W-1:0];
            CSR_OVL_RATIO:   cfg_in.ovl_ratio   = csr_data[RATIO_W-1:0];
            CSR_CLOSE_THR:   cfg_in.close_thr   = csr_data[THR_W-1:0];
            CSR_CLOSE_RATIO: cfg_in.close_ratio = csr_data[RATIO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cause_in = rsp_cause_ff;
      rsp_dist_in  = rsp_dist_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_cause_in = cause;
         rsp_dist_in  = dist_sq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cause_ff <= rsp_cause_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_can_join            = (rsp_cause_ff == CAUSE_NONE);
   assign rsp_reject_cause        = rsp_cause_ff;
   assign rsp_nearest_end_dist_sq = rsp_dist_ff;

   // A compare transfer always occupies the sequencer for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_COMPARE) |=> req_stall)
      else $error("compare transfer did not start the sequencer");

   // A load transfer never starts the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_LOAD) |=> !req_stall)
      else $error("load transfer started the sequencer");

   // A box rejection reports a zero distance.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_reject_cause == CAUSE_X_OVERLAP || rsp_reject_cause == CAUSE_X_GAP
       || rsp_reject_cause == CAUSE_Y_OVERLAP || rsp_reject_cause == CAUSE_Y_GAP))
      |-> (rsp_nearest_end_dist_sq == '0))
      else $error("box rejection carries a nonzero distance");

   // A new result is only produced once the sequencer finishes a compare.
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> $past(req_stall))
      else $error("result appeared without a running compare");

endmodule
